// ----- src/windowed_edit_distance_matcher_unit_assert.svh -----
// Assertion macros used by the matcher unit.
`ifndef WINDOWED_EDIT_DISTANCE_MATCHER_UNIT_ASSERT_SVH
`define WINDOWED_EDIT_DISTANCE_MATCHER_UNIT_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define WEDM_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define WEDM_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/wedm_pkg.sv -----
package wedm_pkg;

  localparam int unsigned MaxPattern = 32;
  localparam int unsigned CountBits  = 32;
  localparam int unsigned LenBits    = $clog2(MaxPattern + 1);
  localparam int unsigned IdxBits    = $clog2(MaxPattern);
  localparam int unsigned DistBits   = 6;
  localparam int unsigned CfgAddrBits = 3;
  localparam int unsigned CfgDataBits = 64;

  localparam logic [CfgAddrBits-1:0] RegThreshold = 3'd0;
  localparam logic [CfgAddrBits-1:0] RegPatLength = 3'd1;
  localparam logic [CfgAddrBits-1:0] RegPatChars0 = 3'd2;
  localparam logic [CfgAddrBits-1:0] RegPatChars3 = 3'd5;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } wedm_in_t;

  typedef struct packed {
    logic [31:0]         window_start;
    logic [DistBits-1:0] edit_distance;
    logic                is_match;
    logic [31:0]         match_total;
    logic                final_window;
  } wedm_out_t;

  // Control shared by every cell of the row.
  typedef struct packed {
    logic               start;   // load boundary values
    logic               busy;    // a window is in work
    logic [LenBits-1:0] size;    // window size s
  } wedm_ctl_t;

endpackage

// ----- src/windowed_edit_distance_matcher_unit.sv -----
// Windowed edit-distance matcher.
// Input channel: in_valid_i/in_stall_o carry one request per text byte with an
// end-of-text flag. Output channel: out_valid_o/out_stall_i carry one result
// per finished window: start offset, distance, match flag, running match count
// and a flag on the last result of the text.
// Configuration is written through cfg_we_i/cfg_addr_i/cfg_data_i while idle.
// Each window is worked out by a row of MaxPattern cells that advance as a
// wavefront, cell y taking each column in the cycle after cell y-1. Each
// further window of an end-of-text flush starts once the previous result was
// taken, and a flush may hold up to 32 windows.
// Only one request is in work at a time: the input stalls from acceptance
// until every result of that byte has been taken.
// A result sits in an output register; while the receiver stalls it holds and
// no further window is started.
// Reset clears the text history, byte and match counters and restores the
// register defaults (threshold 0, pattern length 1, pattern bytes zero).
module windowed_edit_distance_matcher_unit
  import wedm_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  wedm_in_t               in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output wedm_out_t              out_data_o,
  input  logic                   cfg_we_i,
  input  logic [CfgAddrBits-1:0] cfg_addr_i,
  input  logic [CfgDataBits-1:0] cfg_data_i
);

  `include "windowed_edit_distance_matcher_unit_assert.svh"

  typedef enum logic [1:0] {
    StIdle,
    StRun,
    StWait,
    StOut
  } state_e;

  state_e state_q;

  logic [5:0]              thr_q;
  logic [5:0]              plen_q;
  logic [8*MaxPattern-1:0] pat_q;
  logic [7:0]              hist_q [MaxPattern];
  logic [31:0]             seen_q;
  logic [CountBits-1:0]    mcnt_q;
  logic [LenBits-1:0]      fill_q;
  logic [LenBits-1:0]      k_q;      // current window size
  logic                    eot_q;
  logic                    start_q;
  logic                    done;
  logic [DistBits-1:0]     win_dist;
  logic [7:0]              win [MaxPattern];
  logic [LenBits-1:0]      len;
  logic                    is_m;
  logic [CountBits-1:0]    mcnt_n;

  // Effective pattern length, clamped to 1..MaxPattern.
  always_comb begin
    if (plen_q == 6'd0) begin
      len = LenBits'(1);
    end else if ({1'b0, plen_q} > 7'(MaxPattern)) begin
      len = LenBits'(MaxPattern);
    end else begin
      len = LenBits'(plen_q);
    end
  end

  // Window of size k ends at the newest byte: byte x-1 is hist[Max-k+x-1].
  for (genvar i = 0; i < MaxPattern; i++) begin : g_win
    logic [IdxBits:0] src;
    assign src    = (IdxBits+1)'(MaxPattern) - (IdxBits+1)'(k_q) + (IdxBits+1)'(i);
    assign win[i] = hist_q[src[IdxBits-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= '0;
      plen_q <= 6'd1;
      pat_q  <= '0;
    end else if (cfg_we_i) begin
      if (cfg_addr_i == RegThreshold) begin
        thr_q <= cfg_data_i[5:0];
      end else if (cfg_addr_i == RegPatLength) begin
        plen_q <= cfg_data_i[5:0];
      end else if (cfg_addr_i >= RegPatChars0 && cfg_addr_i <= RegPatChars3) begin
        pat_q[64*(cfg_addr_i - RegPatChars0) +: 64] <= cfg_data_i;
      end
    end
  end

  wedm_array u_array (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_q),
    .size_i  (k_q),
    .text_i  (win),
    .pat_i   (pat_q),
    .done_o  (done),
    .dist_o  (win_dist)
  );

  assign is_m   = {1'b0, win_dist} <= {1'b0, thr_q};
  assign mcnt_n = (is_m && mcnt_q != '1) ? mcnt_q + 1'b1 : mcnt_q;

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = (state_q == StOut);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      seen_q     <= '0;
      mcnt_q     <= '0;
      fill_q     <= '0;
      k_q        <= LenBits'(1);
      eot_q      <= 1'b0;
      start_q    <= 1'b0;
      out_data_o <= '0;
      for (int i = 0; i < MaxPattern; i++) hist_q[i] <= '0;
    end else begin
      start_q <= 1'b0;
      case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            for (int i = 0; i + 1 < MaxPattern; i++) hist_q[i] <= hist_q[i+1];
            hist_q[MaxPattern-1] <= in_data_i.text_byte;
            seen_q <= seen_q + 32'd1;
            eot_q  <= in_data_i.end_of_text;
            if (fill_q < LenBits'(MaxPattern)) fill_q <= fill_q + LenBits'(1);
            state_q <= StRun;
          end
        end
        StRun: begin
          if (eot_q) begin
            k_q     <= (fill_q < len) ? fill_q : len;
            start_q <= 1'b1;
            state_q <= StWait;
          end else if (fill_q >= len) begin
            k_q     <= len;
            start_q <= 1'b1;
            state_q <= StWait;
          end else begin
            state_q <= StIdle;
          end
        end
        StWait: begin
          if (done) begin
            mcnt_q <= mcnt_n;
            out_data_o.window_start  <= seen_q - 32'(k_q);
            out_data_o.edit_distance <= win_dist;
            out_data_o.is_match      <= is_m;
            out_data_o.match_total   <= 32'(mcnt_n);
            out_data_o.final_window  <= eot_q && (k_q == LenBits'(1));
            state_q <= StOut;
          end
        end
        StOut: begin
          if (!out_stall_i) begin
            if (eot_q && k_q != LenBits'(1)) begin
              k_q     <= k_q - LenBits'(1);
              start_q <= 1'b1;
              state_q <= StWait;
            end else begin
              if (eot_q) begin
                seen_q <= '0;
                mcnt_q <= '0;
                fill_q <= '0;
                for (int i = 0; i < MaxPattern; i++) hist_q[i] <= '0;
              end
              state_q <= StIdle;
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  `WEDM_ASSERT(a_out_only_final_once, clk_i, rst_ni,
    (out_valid_o && out_data_o.final_window) |-> eot_q, "final flag without end of text")
  `WEDM_ASSERT(a_no_accept_busy, clk_i, rst_ni,
    (state_q == StWait) |-> in_stall_o, "input taken during a window")
  `WEDM_ASSERT(a_start_wait, clk_i, rst_ni,
    start_q |-> (state_q == StWait), "window started outside wait")

endmodule

// ----- src/wedm_cell.sv -----
// One row y of the dynamic programming table. The cell keeps cost[y] of the
// column it last finished and of the column before, and takes the next
// column as soon as the row above has finished it.
module wedm_cell
  import wedm_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  wedm_ctl_t           ctl_i,
  input  logic [DistBits-1:0] init_i,      // boundary cost y
  input  logic [7:0]          pat_i,       // pattern byte y-1
  input  logic [7:0]          text_i [MaxPattern], // window bytes, x-1 order
  input  logic [DistBits-1:0] up_cost_i,   // cost[y-1] of its newest column
  input  logic [DistBits-1:0] up_prev_i,   // cost[y-1] of the column before
  input  logic [LenBits-1:0]  up_col_i,    // columns finished by row y-1
  output logic [DistBits-1:0] cost_o,
  output logic [DistBits-1:0] prev_o,
  output logic [LenBits-1:0]  col_o
);

  logic [DistBits-1:0] cost_q, prev_q;
  logic [LenBits-1:0]  col_q;
  logic [7:0]          tb;
  logic                adv;
  logic [DistBits-1:0] del_c, ins_c, sub_c, best;

  assign tb  = text_i[col_q[IdxBits-1:0]];
  // The next column may be taken once the row above has finished it.
  assign adv = ctl_i.busy && (col_q < ctl_i.size) && (up_col_i > col_q);

  always_comb begin
    del_c = cost_q + DistBits'(1);
    ins_c = up_cost_i + DistBits'(1);
    sub_c = up_prev_i + ((pat_i == tb) ? DistBits'(0) : DistBits'(1));
    best  = (ins_c < del_c) ? ins_c : del_c;
    best  = (sub_c < best) ? sub_c : best;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cost_q <= '0;
      prev_q <= '0;
      col_q  <= '0;
    end else if (ctl_i.start) begin
      cost_q <= init_i;
      prev_q <= init_i;
      col_q  <= '0;
    end else if (adv) begin
      prev_q <= cost_q;
      cost_q <= best;
      col_q  <= col_q + LenBits'(1);
    end
  end

  assign cost_o = cost_q;
  assign prev_o = prev_q;
  assign col_o  = col_q;

endmodule

// ----- src/wedm_array.sv -----
// Row of cells. Each step the whole column advances by one text byte. The
// cells are chained: cell y reads the registered value of cell y-1, so each
// step ripples through the chain in a wavefront, one cell per cycle.
// To keep the chain short per cycle, a column is processed as a wave: cell y
// works on column x after cell y-1 has. Each cell holds its own column index.
module wedm_array
  import wedm_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,     // begin a window
  input  logic [LenBits-1:0]     size_i,      // window size s
  input  logic [7:0]             text_i [MaxPattern], // window bytes, x-1 order
  input  logic [8*MaxPattern-1:0] pat_i,
  output logic                   done_o,
  output logic [DistBits-1:0]    dist_o
);

  // Wavefront: stage y holds cost[y] and the column it last finished.
  logic [DistBits-1:0] cost_w [MaxPattern+1];
  logic [DistBits-1:0] prev_w [MaxPattern+1]; // cost[y] of earlier column
  logic [LenBits-1:0]  col_w  [MaxPattern+1];
  logic [DistBits-1:0] cost0_q, prev0_q;
  logic [LenBits-1:0]  col0_q;
  logic                busy_q;
  logic [LenBits-1:0]  s_q;
  logic [LenBits+1:0]  cyc_q;
  wedm_ctl_t           ctl;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cyc_q  <= '0;
      s_q    <= LenBits'(1);
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cyc_q  <= '0;
        s_q    <= size_i;
      end else if (busy_q) begin
        cyc_q <= cyc_q + 1'b1;
        if (cyc_q == (LenBits+2)'(2 * s_q)) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  assign ctl = '{start: start_i, busy: busy_q, size: s_q};

  // Row 0 boundary: cost[0] = x at column x.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cost0_q <= '0;
      prev0_q <= '0;
      col0_q  <= '0;
    end else if (start_i) begin
      cost0_q <= '0;
      prev0_q <= '0;
      col0_q  <= '0;
    end else if (busy_q && col0_q < s_q) begin
      prev0_q <= cost0_q;
      cost0_q <= cost0_q + DistBits'(1);
      col0_q  <= col0_q + LenBits'(1);
    end
  end

  assign cost_w[0] = cost0_q;
  assign prev_w[0] = prev0_q;
  assign col_w[0]  = col0_q;

  for (genvar y = 1; y <= MaxPattern; y++) begin : g_row
    wedm_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctl_i     (ctl),
      .init_i    (DistBits'(y)),
      .pat_i     (pat_i[8*(y-1) +: 8]),
      .text_i    (text_i),
      .up_cost_i (cost_w[y-1]),
      .up_prev_i (prev_w[y-1]),
      .up_col_i  (col_w[y-1]),
      .cost_o    (cost_w[y]),
      .prev_o    (prev_w[y]),
      .col_o     (col_w[y])
    );
  end

  // cost[y-1] of the previous column must stay until row y uses it: row y
  // advances in the cycle after row y-1, and row y-1 cannot advance
  // again before row y has caught up, as it waits on row y-2 likewise.
  // With the wave each row trails the row above, so prev is the right diagonal.
  assign dist_o = cost_w[s_q];

endmodule

// ----- tb/testbench.sv -----
module testbench;
  import wedm_pkg::*;

  // Clock and the single reset at the start of the run.
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Request side, result side and the register write port.
  logic                   in_valid_i = 1'b0;
  logic                   in_stall_o;
  wedm_in_t               in_data_i = '0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  wedm_out_t              out_data_o;
  logic                   cfg_we_i = 1'b0;
  logic [CfgAddrBits-1:0] cfg_addr_i = '0;
  logic [CfgDataBits-1:0] cfg_data_i = '0;

  windowed_edit_distance_matcher_unit i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_data_i (cfg_data_i)
  );

  // The testbench's own copy of the registers and the text state.
  logic [5:0]  thr_q;
  logic [5:0]  plen_q;
  logic [63:0] pchars_q [4];
  logic [7:0]  history_q [MaxPattern];
  logic [31:0] seen_q;
  logic [31:0] hits_q;
  int unsigned held_q;

  // Windows expected from the block, oldest first.
  wedm_out_t   pending_windows [$];
  int unsigned errors = 0;

  // Directed requests: a byte, the end flag and, where obvious, the first
  // window that byte must produce.
  typedef struct {
    logic [7:0] b;
    logic       eot;
    logic       known;
    wedm_out_t  first;
  } directed_row_t;

  function automatic logic [7:0] pattern_byte(int unsigned y);
    if (y >= 32) return 8'h00;
    return pchars_q[y/8][(y%8)*8 +: 8];
  endfunction

  function automatic int unsigned active_length();
    if (plen_q == 0) return 1;
    if (plen_q > MaxPattern) return MaxPattern;
    return plen_q;
  endfunction

  // Levenshtein distance of the newest s bytes against the pattern prefix.
  function automatic int unsigned window_cost(int unsigned s);
    int unsigned col [MaxPattern+1];
    int unsigned diag, old, best, c;
    logic [7:0] t;
    for (int unsigned y = 0; y <= s; y++) col[y] = y;
    for (int unsigned x = 1; x <= s; x++) begin
      t = history_q[MaxPattern - s + x - 1];
      col[0] = x;
      diag = x - 1;
      for (int unsigned y = 1; y <= s; y++) begin
        old = col[y];
        best = col[y] + 1;
        if (col[y-1] + 1 < best) best = col[y-1] + 1;
        c = diag + ((pattern_byte(y-1) == t) ? 0 : 1);
        if (c < best) best = c;
        col[y] = best;
        diag = old;
      end
    end
    return col[s];
  endfunction

  function automatic void queue_window(int unsigned s, logic last);
    wedm_out_t w;
    int unsigned d;
    d = window_cost(s);
    w.edit_distance = d[5:0];
    w.is_match = (d <= thr_q);
    if (w.is_match && hits_q != 32'hFFFF_FFFF) hits_q++;
    w.window_start = seen_q - s;
    w.match_total = hits_q;
    w.final_window = last;
    pending_windows.push_back(w);
  endfunction

  // Advances the predicted text state for one accepted request.
  function automatic void predict_byte(wedm_in_t r);
    int unsigned len, avail;
    len = active_length();
    for (int i = 0; i < MaxPattern - 1; i++) history_q[i] = history_q[i+1];
    history_q[MaxPattern-1] = r.text_byte;
    seen_q++;
    if (held_q < MaxPattern) held_q++;
    if (!r.end_of_text) begin
      if (held_q >= len) queue_window(len, 1'b0);
    end else begin
      avail = (held_q < len) ? held_q : len;
      for (int unsigned k = avail; k >= 1; k--) queue_window(k, k == 1);
      for (int i = 0; i < MaxPattern; i++) history_q[i] = 8'h00;
      seen_q = 0;
      hits_q = 0;
      held_q = 0;
    end
  endfunction

  function automatic void clear_model();
    thr_q = 6'd0;
    plen_q = 6'd1;
    for (int i = 0; i < 4; i++) pchars_q[i] = '0;
    for (int i = 0; i < MaxPattern; i++) history_q[i] = 8'h00;
    seen_q = 0;
    hits_q = 0;
    held_q = 0;
  endfunction

  task automatic write_reg(logic [CfgAddrBits-1:0] idx, logic [63:0] val);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == RegThreshold) thr_q = val[5:0];
    else if (idx == RegPatLength) plen_q = val[5:0];
    else if (idx >= RegPatChars0 && idx <= RegPatChars3) pchars_q[idx - RegPatChars0] = val;
    @(posedge clk_i);
  endtask

  // Waits for every expected window, then for the block's worst latency, since
  // a plain byte before the pattern has filled can leave no result behind.
  task automatic drain();
    while (pending_windows.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  // Hands one request over and holds it until accepted; a random gap follows
  // now and then so that pauses fall on every phase of the work.
  int unsigned burst_left = 0;
  task automatic send_byte(logic [7:0] b, logic eot);
    wedm_in_t r;
    r.text_byte = b;
    r.end_of_text = eot;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      repeat ($urandom_range(0, 6)) @(posedge clk_i);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_data_i <= r;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_byte(r);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // The receiver stalls in runs of its own, with long spells of no stall.
  int unsigned stall_run = 0;
  always @(posedge clk_i) begin
    if (stall_run != 0) begin
      stall_run <= stall_run - 1;
    end else begin
      stall_run <= $urandom_range(0, 20);
      out_stall_i <= ($urandom_range(0, 2) == 0) ? ~out_stall_i : 1'b0;
    end
  end

  // Each result taken is checked against the oldest expected window.
  always @(posedge clk_i) begin
    wedm_out_t w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_windows.size() == 0) begin
        $error("unexpected result, window_start %0d", out_data_o.window_start);
        errors++;
      end else begin
        w = pending_windows.pop_front();
        if (out_data_o.window_start !== w.window_start) begin
          $error("window_start exp %0d got %0d", w.window_start, out_data_o.window_start);
          errors++;
        end
        if (out_data_o.edit_distance !== w.edit_distance) begin
          $error("edit_distance exp %0d got %0d", w.edit_distance, out_data_o.edit_distance);
          errors++;
        end
        if (out_data_o.is_match !== w.is_match) begin
          $error("is_match exp %0d got %0d", w.is_match, out_data_o.is_match);
          errors++;
        end
        if (out_data_o.match_total !== w.match_total) begin
          $error("match_total exp %0d got %0d", w.match_total, out_data_o.match_total);
          errors++;
        end
        if (out_data_o.final_window !== w.final_window) begin
          $error("final_window exp %0d got %0d", w.final_window, out_data_o.final_window);
          errors++;
        end
      end
    end
  end

  // A generous ceiling on the whole run.
  initial begin
    #30000000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    directed_row_t rows [$];
    directed_row_t row;
    wedm_out_t w;
    int unsigned len;
    clear_model();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // After reset the pattern is one zero byte: a zero byte hits at distance
    // 0, byte FF misses, and an end flag on the first byte of a text flushes one.
    row = '{b: 8'h00, eot: 1'b0, known: 1'b1,
            first: '{32'd0, 6'd0, 1'b1, 32'd1, 1'b0}};
    rows.push_back(row);
    row = '{b: 8'hFF, eot: 1'b0, known: 1'b1,
            first: '{32'd1, 6'd1, 1'b0, 32'd1, 1'b0}};
    rows.push_back(row);
    row = '{b: 8'hFF, eot: 1'b1, known: 1'b1,
            first: '{32'd2, 6'd1, 1'b0, 32'd1, 1'b1}};
    rows.push_back(row);
    row = '{b: 8'h00, eot: 1'b1, known: 1'b1,
            first: '{32'd0, 6'd0, 1'b1, 32'd1, 1'b1}};
    rows.push_back(row);
    foreach (rows[i]) begin
      send_byte(rows[i].b, rows[i].eot);
      if (rows[i].known) begin
        w = pending_windows[pending_windows.size() - 1];
        if (w !== rows[i].first) begin
          $error("directed row %0d: predictor disagrees with table", i);
          errors++;
        end
      end
    end
    drain();

    // Longest pattern of one repeated byte, text shorter than the pattern.
    write_reg(RegPatLength, 64'd63);
    write_reg(RegThreshold, 64'd63);
    for (int i = 0; i < 4; i++) write_reg(CfgAddrBits'(RegPatChars0 + i), {8{8'hFF}});
    for (int i = 0; i < 20; i++) send_byte((i % 3 == 0) ? 8'hFF : 8'h00, i == 19);
    drain();

    // Random phases with varied settings; most text is drawn from the pattern's
    // own bytes so that near-matches occur, the rest is noise.
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(RegThreshold, 64'($urandom_range(0, 63)));
      write_reg(RegPatLength,
                (ph == 0) ? 64'd0 : (ph == 1) ? 64'd32 : 64'($urandom_range(1, 8)));
      for (int i = 0; i < 4; i++) write_reg(CfgAddrBits'(RegPatChars0 + i), {$urandom, $urandom});
      len = active_length();
      for (int n = 0; n < 35; n++) begin
        logic [7:0] b;
        b = ($urandom_range(0, 3) != 0) ? pattern_byte($urandom_range(0, len - 1))
                                        : 8'($urandom);
        send_byte(b, (n == 34) || ($urandom_range(0, 24) == 0));
      end
      // A full pause until every window of the phase has come out.
      drain();
    end

    if (errors == 0 && pending_windows.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

// ----- files.f -----
+incdir+src
src/wedm_pkg.sv
src/wedm_cell.sv
src/wedm_array.sv
src/windowed_edit_distance_matcher_unit.sv
tb/testbench.sv
